@@ rtl/core/avimd_pkg.sv @@
// Shared types and constants for the AVI movi chunk demultiplexer.
`timescale 1ns / 1ps
package avimd_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned ByteW = 8;
  localparam int unsigned KindW = 3;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [WordW-1:0] TAG_VIDEO = 32'h6364_3030;  // "00dc"
  localparam logic [WordW-1:0] TAG_AUDIO = 32'h6277_3130;  // "01wb"
  localparam logic [WordW-1:0] HDR_BYTES = 32'd8;

  localparam logic [KindW-1:0] KIND_VIDEO = 3'd0;
  localparam logic [KindW-1:0] KIND_AUDIO = 3'd1;
  localparam logic [KindW-1:0] KIND_EMPTY = 3'd2;
  localparam logic [KindW-1:0] KIND_END   = 3'd3;
  localparam logic [KindW-1:0] KIND_BAD   = 3'd4;

  localparam logic [CfgIdxW-1:0] REG_MOVI_START = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_MOVI_END   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_AUDIO_EN   = 2'd2;

  typedef struct packed {
    logic [WordW-1:0] movi_start_offset;
    logic [WordW-1:0] movi_end_offset;
    logic             audio_enabled;
    logic             restart;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] data;
  } stage_t;

endpackage

@@ rtl/core/avimd_if.sv @@
// Valid/ready channel interfaces for the byte input and the result output.
`timescale 1ns / 1ps
interface avimd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface avimd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [2:0]  kind;
  logic        chunk_last;
  logic [31:0] chunk_length;

  modport source (output valid, output out_byte, output kind, output chunk_last,
                  output chunk_length, input ready);
  modport sink (input valid, input out_byte, input kind, input chunk_last,
                input chunk_length, output ready);
endinterface

@@ rtl/core/avi_movi_chunk_demux_core.sv @@
// Top level of the AVI movi chunk demultiplexer.
// The block takes one file byte per clock unless a held result stalls it, and gives at most
// one result per byte. A byte is parsed in the cycle in which it is taken from the input
// register, and its result, if any, is in the output register from the next clock edge; the
// sustained rate of one byte per cycle is set by the single per-byte parse pass whose
// longest path is the 33-bit chunk bound check on the last header byte. A result held by
// the receiver stalls the input. After reset or a write of movi_start_offset, parsing
// starts at a chunk header; after an end-of-movi or corrupt-size result, bytes are taken
// and dropped until movi_start_offset is written.
`timescale 1ns / 1ps
module avi_movi_chunk_demux_core (
  input  logic                            clk,
  input  logic                            rst_n,
  avimd_in_if.sink                        in_ch,
  avimd_out_if.source                     out_ch,
  input  logic                            cfg_we,
  input  logic [avimd_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [avimd_pkg::WordW-1:0]     cfg_data
);

  avimd_pkg::cfg_t   cfg;
  avimd_pkg::stage_t stage;
  logic              take;

  avimd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  avimd_in_stage u_in (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .take  (take),
    .stage (stage)
  );

  avimd_parser u_parse (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .stage  (stage),
    .take   (take),
    .out_ch (out_ch)
  );

endmodule

@@ rtl/core/avimd_cfg_regs.sv @@
// Configuration registers with a restart pulse on a movi start write.
`timescale 1ns / 1ps
module avimd_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [avimd_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [avimd_pkg::WordW-1:0]         cfg_data,
  output avimd_pkg::cfg_t                     cfg
);

  logic [avimd_pkg::WordW-1:0] start_r;
  logic [avimd_pkg::WordW-1:0] end_r;
  logic                        audio_r;
  logic                        restart;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      end_r   <= '0;
      audio_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        avimd_pkg::REG_MOVI_START: start_r <= cfg_data;
        avimd_pkg::REG_MOVI_END:   end_r   <= cfg_data;
        avimd_pkg::REG_AUDIO_EN:   audio_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign restart = cfg_we && (cfg_index == avimd_pkg::REG_MOVI_START);

  // parser reloads from the written value in the same cycle
  assign cfg.movi_start_offset = restart ? cfg_data : start_r;
  assign cfg.movi_end_offset   = end_r;
  assign cfg.audio_enabled     = audio_r;
  assign cfg.restart           = restart;

endmodule

@@ rtl/core/avimd_in_stage.sv @@
// Input register for one file byte.
`timescale 1ns / 1ps
module avimd_in_stage (
  input  logic                          clk,
  input  logic                          rst_n,
  avimd_in_if.sink                      in_ch,
  input  logic                          take,
  output avimd_pkg::stage_t             stage
);

  logic                        valid_r;
  logic [avimd_pkg::ByteW-1:0] data_r;

  assign in_ch.ready = !valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      data_r <= in_ch.data_byte;
    end
  end

  assign stage.valid = valid_r;
  assign stage.data  = data_r;

endmodule

@@ rtl/core/avimd_parser.sv @@
// Chunk parser state and the result register.
`timescale 1ns / 1ps
module avimd_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  avimd_pkg::cfg_t       cfg,
  input  avimd_pkg::stage_t     stage,
  output logic                  take,
  avimd_out_if.source           out_ch
);

  localparam logic [1:0] MODE_HEADER = 2'd0;
  localparam logic [1:0] MODE_VIDEO  = 2'd1;
  localparam logic [1:0] MODE_AUDIO  = 2'd2;
  localparam logic [1:0] MODE_SKIP   = 2'd3;

  logic [31:0] pos_r, pos_nxt;
  logic [2:0]  hidx_r, hidx_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic [23:0] size_lo_r, size_lo_nxt;
  logic [31:0] clen_r, clen_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic        pad_r, pad_nxt;
  logic        ended_r, ended_nxt;

  logic        ov_r;
  logic [7:0]  ob_r;
  logic [2:0]  okind_r;
  logic        olast_r;
  logic [31:0] olen_r;

  logic        emit;
  logic [7:0]  eb;
  logic [2:0]  ekind;
  logic        elast;
  logic [31:0] elen;

  logic [7:0]  b;
  logic [32:0] hdr_end;
  logic [31:0] size_full;
  logic        size_pad;
  logic [32:0] next_pos;
  logic [31:0] run;
  logic        rem_le1;

  assign b         = stage.data;
  assign take      = stage.valid && (!ov_r || out_ch.ready);
  assign hdr_end   = {1'b0, pos_r} + {1'b0, avimd_pkg::HDR_BYTES};
  assign size_full = {b, size_lo_r};
  assign size_pad  = size_lo_r[0];
  // pos_r is the last header byte; next chunk starts at pos + 1 + size + pad
  assign next_pos  = {1'b0, pos_r} + {1'b0, size_full} + 33'd1 + {32'd0, size_pad};
  assign run       = size_full + {31'd0, size_pad};
  assign rem_le1   = (rem_r[31:1] == 31'd0);

  always_comb begin
    pos_nxt     = pos_r;
    hidx_nxt    = hidx_r;
    tag_nxt     = tag_r;
    size_lo_nxt = size_lo_r;
    clen_nxt    = clen_r;
    rem_nxt     = rem_r;
    mode_nxt    = mode_r;
    pad_nxt     = pad_r;
    ended_nxt   = ended_r;
    emit        = 1'b0;
    eb          = 8'd0;
    ekind       = avimd_pkg::KIND_VIDEO;
    elast       = 1'b0;
    elen        = 32'd0;
    if (!ended_r) begin
      if (mode_r == MODE_HEADER) begin
        if ((hidx_r == 3'd0) && (hdr_end > {1'b0, cfg.movi_end_offset})) begin
          ended_nxt = 1'b1;
          emit      = 1'b1;
          ekind     = avimd_pkg::KIND_END;
        end else begin
          case (hidx_r)
            3'd0:    tag_nxt[7:0]       = b;
            3'd1:    tag_nxt[15:8]      = b;
            3'd2:    tag_nxt[23:16]     = b;
            3'd3:    tag_nxt[31:24]     = b;
            3'd4:    size_lo_nxt[7:0]   = b;
            3'd5:    size_lo_nxt[15:8]  = b;
            3'd6:    size_lo_nxt[23:16] = b;
            default: size_lo_nxt        = size_lo_r;
          endcase
          pos_nxt  = pos_r + 32'd1;
          hidx_nxt = hidx_r + 3'd1;
          if (hidx_r == 3'd7) begin
            clen_nxt = size_full;
            if (next_pos > {1'b0, cfg.movi_end_offset}) begin
              ended_nxt = 1'b1;
              emit      = 1'b1;
              ekind     = avimd_pkg::KIND_BAD;
              elen      = size_full;
            end else if (tag_r == avimd_pkg::TAG_VIDEO) begin
              if (size_full == 32'd0) begin
                emit  = 1'b1;
                ekind = avimd_pkg::KIND_EMPTY;
              end else begin
                mode_nxt = MODE_VIDEO;
                rem_nxt  = size_full;
                pad_nxt  = size_pad;
              end
            end else if ((tag_r == avimd_pkg::TAG_AUDIO) && (size_full != 32'd0)
                         && cfg.audio_enabled) begin
              mode_nxt = MODE_AUDIO;
              rem_nxt  = size_full;
              pad_nxt  = size_pad;
            end else begin
              pad_nxt = 1'b0;
              if (run != 32'd0) begin
                mode_nxt = MODE_SKIP;
                rem_nxt  = run;
              end
            end
          end
        end
      end else begin
        pos_nxt = pos_r + 32'd1;
        if (mode_r == MODE_SKIP) begin
          if (rem_le1) begin
            rem_nxt  = 32'd0;
            mode_nxt = MODE_HEADER;
          end else begin
            rem_nxt = rem_r - 32'd1;
          end
        end else begin
          emit  = 1'b1;
          eb    = b;
          ekind = (mode_r == MODE_VIDEO) ? avimd_pkg::KIND_VIDEO : avimd_pkg::KIND_AUDIO;
          elast = rem_le1;
          elen  = clen_r;
          if (rem_le1) begin
            if (pad_r) begin
              pad_nxt  = 1'b0;
              mode_nxt = MODE_SKIP;
              rem_nxt  = 32'd1;
            end else begin
              mode_nxt = MODE_HEADER;
              rem_nxt  = 32'd0;
            end
          end else begin
            rem_nxt = rem_r - 32'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      hidx_r    <= '0;
      tag_r     <= '0;
      size_lo_r <= '0;
      clen_r    <= '0;
      rem_r     <= '0;
      mode_r    <= MODE_HEADER;
      pad_r     <= 1'b0;
      ended_r   <= 1'b0;
    end else if (cfg.restart) begin
      pos_r     <= cfg.movi_start_offset;
      hidx_r    <= '0;
      tag_r     <= '0;
      size_lo_r <= '0;
      clen_r    <= '0;
      rem_r     <= '0;
      mode_r    <= MODE_HEADER;
      pad_r     <= 1'b0;
      ended_r   <= 1'b0;
    end else if (take) begin
      pos_r     <= pos_nxt;
      hidx_r    <= hidx_nxt;
      tag_r     <= tag_nxt;
      size_lo_r <= size_lo_nxt;
      clen_r    <= clen_nxt;
      rem_r     <= rem_nxt;
      mode_r    <= mode_nxt;
      pad_r     <= pad_nxt;
      ended_r   <= ended_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (take && emit) begin
      ov_r <= 1'b1;
    end else if (out_ch.ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      ob_r    <= eb;
      okind_r <= ekind;
      olast_r <= elast;
      olen_r  <= elen;
    end
  end

  assign out_ch.valid        = ov_r;
  assign out_ch.out_byte     = ob_r;
  assign out_ch.kind         = okind_r;
  assign out_ch.chunk_last   = olast_r;
  assign out_ch.chunk_length = olen_r;

endmodule

@@ rtl/core/avimd_chk.sv @@
// Port-level checker for the demultiplexer and its bind.
`timescale 1ns / 1ps
module avimd_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic [2:0]  kind,
  input logic        chunk_last,
  input logic [31:0] chunk_length
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(kind)
      && $stable(chunk_last) && $stable(chunk_length))
    else $error("stalled result changed");

  a_end_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (kind == avimd_pkg::KIND_END) |-> (out_byte == 8'd0) && !chunk_last
      && (chunk_length == 32'd0))
    else $error("end-of-movi result carries payload");

  a_marker_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((kind == avimd_pkg::KIND_EMPTY) || (kind == avimd_pkg::KIND_BAD))
      |-> (out_byte == 8'd0) && !chunk_last
        && ((kind == avimd_pkg::KIND_BAD) || (chunk_length == 32'd0)))
    else $error("marker result carries body data");

endmodule

bind avi_movi_chunk_demux_core avimd_chk u_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_byte     (out_ch.out_byte),
  .kind         (out_ch.kind),
  .chunk_last   (out_ch.chunk_last),
  .chunk_length (out_ch.chunk_length)
);

@@ dv/avimd_checker.sv @@
// Checker for the AVI movi chunk demultiplexer: predicts results from observed transfers.
`timescale 1ns / 1ps
module avimd_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  avimd_in_if                            in_mon,
  avimd_out_if                           out_mon,
  input  logic                           cfg_we,
  input  logic [avimd_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [avimd_pkg::WordW-1:0]    cfg_data,
  output int unsigned                    n_errors,
  output int unsigned                    n_pending,
  output int unsigned                    n_bytes_in,
  output int unsigned                    n_video,
  output int unsigned                    n_audio,
  output int unsigned                    n_marker
);

  typedef enum logic [1:0] {PH_HEADER, PH_VIDEO, PH_AUDIO, PH_SKIP} parse_phase_e;

  typedef struct packed {
    logic [avimd_pkg::ByteW-1:0] data;
    logic [avimd_pkg::KindW-1:0] kind;
    logic                        last;
    logic [avimd_pkg::WordW-1:0] len;
  } demux_result_t;

  demux_result_t demux_results_q[$];

  logic [avimd_pkg::WordW-1:0] start_ofs, end_ofs;
  logic                        audio_on;

  logic [avimd_pkg::WordW-1:0] file_pos, chunk_tag, chunk_size, body_left;
  logic [2:0]                  hdr_idx;
  parse_phase_e                phase;
  logic                        pad_due, stream_done;

  function automatic void restart_parse();
    file_pos    = start_ofs;
    hdr_idx     = '0;
    chunk_tag   = '0;
    chunk_size  = '0;
    body_left   = '0;
    phase       = PH_HEADER;
    pad_due     = 1'b0;
    stream_done = 1'b0;
  endfunction

  function automatic void queue_result(input logic [avimd_pkg::ByteW-1:0] data,
                                       input logic [avimd_pkg::KindW-1:0] kind,
                                       input logic last,
                                       input logic [avimd_pkg::WordW-1:0] len);
    demux_result_t r;
    r.data = data;
    r.kind = kind;
    r.last = last;
    r.len  = len;
    demux_results_q.push_back(r);
  endfunction

  function automatic void demux_byte(input logic [avimd_pkg::ByteW-1:0] b);
    logic [avimd_pkg::WordW:0]   bound;
    logic [avimd_pkg::WordW-1:0] run;
    if (stream_done) return;
    if (phase == PH_HEADER) begin
      if (hdr_idx == 3'd0) begin
        if ({1'b0, file_pos} + {1'b0, avimd_pkg::HDR_BYTES} > {1'b0, end_ofs}) begin
          stream_done = 1'b1;
          queue_result('0, avimd_pkg::KIND_END, 1'b0, '0);
          return;
        end
        chunk_tag  = '0;
        chunk_size = '0;
      end
      if (!hdr_idx[2]) chunk_tag[{hdr_idx[1:0], 3'b000} +: 8] = b;
      else chunk_size[{hdr_idx[1:0], 3'b000} +: 8] = b;
      file_pos = file_pos + 1;
      hdr_idx  = hdr_idx + 3'd1;
      if (hdr_idx != 3'd0) return;
      // full-width bound: header end + body + pad must stay within movi
      bound = {1'b0, file_pos} + {1'b0, chunk_size} + chunk_size[0];
      if (bound > {1'b0, end_ofs}) begin
        stream_done = 1'b1;
        queue_result('0, avimd_pkg::KIND_BAD, 1'b0, chunk_size);
        return;
      end
      if (chunk_tag == avimd_pkg::TAG_VIDEO) begin
        if (chunk_size == '0) begin
          queue_result('0, avimd_pkg::KIND_EMPTY, 1'b0, '0);
          return;
        end
        phase     = PH_VIDEO;
        body_left = chunk_size;
        pad_due   = chunk_size[0];
      end else if (chunk_tag == avimd_pkg::TAG_AUDIO && chunk_size != '0 && audio_on) begin
        phase     = PH_AUDIO;
        body_left = chunk_size;
        pad_due   = chunk_size[0];
      end else begin
        run     = chunk_size + chunk_size[0];
        pad_due = 1'b0;
        if (run != '0) begin
          phase     = PH_SKIP;
          body_left = run;
        end
      end
      return;
    end
    file_pos = file_pos + 1;
    if (phase == PH_SKIP) begin
      if (body_left <= 1) begin
        body_left = '0;
        phase     = PH_HEADER;
      end else begin
        body_left = body_left - 1;
      end
      return;
    end
    queue_result(b, (phase == PH_VIDEO) ? avimd_pkg::KIND_VIDEO : avimd_pkg::KIND_AUDIO,
                 body_left <= 1, chunk_size);
    if (body_left <= 1) begin
      body_left = '0;
      if (pad_due) begin
        pad_due   = 1'b0;
        phase     = PH_SKIP;
        body_left = 1;
      end else begin
        phase = PH_HEADER;
      end
    end else begin
      body_left = body_left - 1;
    end
  endfunction

  function automatic void note_fail(input string what, input demux_result_t want,
                                    input demux_result_t got);
    n_errors++;
    if (n_errors <= 10)
      $display({"%0t: %s: expected byte %02h kind %0d last %0d len %08h,",
                " got byte %02h kind %0d last %0d len %08h"},
               $time, what, want.data, want.kind, want.last, want.len,
               got.data, got.kind, got.last, got.len);
  endfunction

  always @(posedge clk) begin
    demux_result_t got, want;
    if (!rst_n) begin
      start_ofs  = '0;
      end_ofs    = '0;
      audio_on   = 1'b0;
      restart_parse();
      demux_results_q.delete();
      n_errors   = 0;
      n_bytes_in = 0;
      n_video    = 0;
      n_audio    = 0;
      n_marker   = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.data = out_mon.out_byte;
        got.kind = out_mon.kind;
        got.last = out_mon.chunk_last;
        got.len  = out_mon.chunk_length;
        if (got.kind == avimd_pkg::KIND_VIDEO) n_video++;
        else if (got.kind == avimd_pkg::KIND_AUDIO) n_audio++;
        else n_marker++;
        if (demux_results_q.size() == 0) begin
          note_fail("result transfer with nothing expected", '0, got);
        end else begin
          want = demux_results_q.pop_front();
          if (got.data !== want.data || got.kind !== want.kind ||
              got.last !== want.last || got.len !== want.len)
            note_fail("result mismatch", want, got);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          avimd_pkg::REG_MOVI_START: begin
            start_ofs = cfg_data;
            restart_parse();
          end
          avimd_pkg::REG_MOVI_END: end_ofs = cfg_data;
          avimd_pkg::REG_AUDIO_EN: audio_on = cfg_data[0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        n_bytes_in++;
        demux_byte(in_mon.data_byte);
      end
    end
    n_pending <= demux_results_q.size();
  end

endmodule

@@ dv/testbench.sv @@
// Top of the demultiplexer testbench: clock, reset, movi byte streams, config and verdict.
`timescale 1ns / 1ps
module testbench;

  localparam logic [avimd_pkg::CfgIdxW-1:0] REG_SPARE = 2'd3;
  localparam int unsigned RANDOM_BYTES = 2000;
  localparam int unsigned HOLD_CYCLES  = 80;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [avimd_pkg::CfgIdxW-1:0] cfg_index;
  logic [avimd_pkg::WordW-1:0]   cfg_data;

  avimd_in_if  in_ch ();
  avimd_out_if out_ch ();

  int unsigned n_errors, n_pending, n_bytes_in, n_video, n_audio, n_marker;
  int unsigned snd_idle_pct, rcv_idle_pct, stream_bytes, n_streams;
  int unsigned hold_left = 0;
  logic        hold_req;
  logic        hold_seen = 1'b0;
  logic [63:0] rd_pos;

  avi_movi_chunk_demux_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  avimd_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .n_errors   (n_errors),
    .n_pending  (n_pending),
    .n_bytes_in (n_bytes_in),
    .n_video    (n_video),
    .n_audio    (n_audio),
    .n_marker   (n_marker)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off on each toggle of hold_req
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen    <= hold_req;
      hold_left    <= HOLD_CYCLES - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  task automatic put_byte(input logic [7:0] b, input bit counted);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    if (counted) begin
      stream_bytes++;
      if (stream_bytes == 150 || stream_bytes == 1500) hold_req <= ~hold_req;
    end
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic put_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) put_byte(w[8*i +: 8], 1'b1);
  endtask

  task automatic put_chunk(input logic [31:0] tag, input logic [31:0] size, input bit hdr_only);
    put_word(tag);
    put_word(size);
    if (!hdr_only) begin
      for (int unsigned i = 0; i < size; i++) put_byte($urandom_range(255), 1'b1);
      if (size[0]) put_byte($urandom_range(255), 1'b1);
      rd_pos = rd_pos + 8 + size + size[0];
    end
  endtask

  task automatic write_reg(input logic [avimd_pkg::CfgIdxW-1:0] idx,
                           input logic [avimd_pkg::WordW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // wait for all expected results, then let the pipeline empty
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic run_stream();
    logic [31:0] start, tag, size;
    logic [63:0] stop, room;
    int unsigned budget;
    bit          broke;
    case ($urandom_range(7))
      0: start = 32'h0;
      1: start = $urandom;
      2: start = 32'hFFFF_FFFF - $urandom_range(0, 320);
      default: start = $urandom_range(0, 65535);
    endcase
    budget = ($urandom_range(9) == 0) ? $urandom_range(0, 12) : $urandom_range(16, 300);
    stop = {32'h0, start} + budget;
    if (stop > 64'hFFFF_FFFF) stop = 64'hFFFF_FFFF;
    if ($urandom_range(15) == 0 && start != 0) stop = {32'h0, start} - 1;
    write_reg(avimd_pkg::REG_MOVI_END, stop[31:0]);
    write_reg(avimd_pkg::REG_AUDIO_EN, $urandom_range(1));
    write_reg(avimd_pkg::REG_MOVI_START, start);
    n_streams++;
    rd_pos = {32'h0, start};
    broke  = 1'b0;
    while (!broke && rd_pos + 8 <= stop) begin
      room = stop - rd_pos - 8;
      case ($urandom_range(9))
        0, 1, 2, 3: tag = avimd_pkg::TAG_VIDEO;
        4, 5, 6:    tag = avimd_pkg::TAG_AUDIO;
        7:          tag = $urandom;
        8:          tag = avimd_pkg::TAG_VIDEO ^ (32'h1 << $urandom_range(31));
        default:    tag = avimd_pkg::TAG_AUDIO ^ (32'h1 << $urandom_range(31));
      endcase
      case ($urandom_range(9))
        0, 1:    size = 0;
        9:       size = $urandom_range(25, 120);
        default: size = $urandom_range(1, 24);
      endcase
      if ({32'h0, size} + size[0] > room) begin
        if ($urandom_range(3) == 0) begin
          size  = $urandom_range(1) ? ($urandom | 32'h8000_0000)
                                    : (room[31:0] + 32'd1 + $urandom_range(0, 2));
          broke = 1'b1;
        end else begin
          size = room[31:0];
          if (size[0]) size = size - 1;
        end
      end
      put_chunk(tag, size, broke);
    end
    if (!broke) put_byte($urandom_range(255), 1'b1);
    repeat ($urandom_range(0, 3)) put_byte($urandom_range(255), 1'b0);
    settle();
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    hold_req        = 1'b0;
    snd_idle_pct    = 14;
    rcv_idle_pct    = 55;
    stream_bytes    = 0;
    n_streams       = 0;
    rd_pos          = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset registers: movi end 0, so the first byte ends the stream
    put_byte(8'hA5, 1'b1);
    settle();

    // empty video frame, odd video and audio chunks with pads, then end of movi
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    write_reg(avimd_pkg::REG_MOVI_END, 32'd28);
    write_reg(avimd_pkg::REG_AUDIO_EN, 32'd1);
    write_reg(avimd_pkg::REG_MOVI_START, 32'd0);
    put_word(avimd_pkg::TAG_VIDEO);
    put_word(32'd0);
    put_word(avimd_pkg::TAG_VIDEO);
    put_word(32'd1);
    put_byte(8'hFF, 1'b1);
    put_byte(8'h00, 1'b1);
    put_word(avimd_pkg::TAG_AUDIO);
    put_word(32'd1);
    put_byte(8'h00, 1'b1);
    put_byte(8'hFF, 1'b1);
    put_byte(8'h5A, 1'b1);
    settle();

    // corrupt size at the top of the address space
    write_reg(avimd_pkg::REG_MOVI_END, 32'hFFFF_FFFF);
    write_reg(avimd_pkg::REG_MOVI_START, 32'hFFFF_FFF0);
    put_word(~avimd_pkg::TAG_AUDIO);
    put_word(32'hFFFF_FFFF);
    settle();

    // header start + 8 carries past 32 bits
    write_reg(avimd_pkg::REG_AUDIO_EN, 32'd0);
    write_reg(avimd_pkg::REG_MOVI_START, 32'hFFFF_FFF8);
    put_byte(8'h00, 1'b1);
    settle();
    n_streams = 4;

    stream_bytes = 0;
    while (stream_bytes < RANDOM_BYTES) begin
      if (stream_bytes < RANDOM_BYTES / 3) begin
        snd_idle_pct = 14;
        rcv_idle_pct <= 55;
      end else if (stream_bytes < 2 * RANDOM_BYTES / 3) begin
        snd_idle_pct = 55;
        rcv_idle_pct <= 14;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct <= 0;
      end
      run_stream();
    end

    $display("Coverage: %0d streams, %0d bytes taken, %0d video and %0d audio bytes routed,",
             n_streams, n_bytes_in, n_video, n_audio);
    $display("          %0d empty-frame/end/corrupt markers, %0d results still pending",
             n_marker, n_pending);
    if (n_errors == 0 && n_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
